>>> rtl/pse_pkg.sv
package pse_pkg;

	localparam int PSE_STACK_DEPTH = 16;
	localparam int PSE_DATA_WIDTH  = 32;

	// Item commands.
	localparam logic [2:0] CMD_PUSH = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_END  = 3'd5;

	// Result status codes.
	localparam logic [2:0] STAT_OK   = 3'd0;
	localparam logic [2:0] STAT_FEW  = 3'd1;
	localparam logic [2:0] STAT_DIVZ = 3'd2;
	localparam logic [2:0] STAT_LEFT = 3'd3;
	localparam logic [2:0] STAT_OVF  = 3'd4;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] operand;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} result_t;

	// Request from the sequencer to the multiply/divide unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctrl_t;

	// Status back from the multiply/divide unit.
	typedef struct packed {
		logic busy;
		logic done;
	} md_stat_t;

endpackage

>>> rtl/pse_muldiv.sv
module pse_muldiv import pse_pkg::*; #(
	parameter int DATA_WIDTH = PSE_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md_ctrl_t              ctrl,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output md_stat_t              stat,
	output logic [DATA_WIDTH-1:0] res
);

	localparam int W  = DATA_WIDTH;
	localparam int IW = $clog2(W + 1);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIX
	} md_state_t;

	md_state_t       state_q;
	logic [IW-1:0]   iter_q;
	logic            div_q;
	logic            neg_q;
	logic            done_q;
	logic [W-1:0]    acc_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    opnd_q;
	logic [W-1:0]    res_q;

	logic [W-1:0]    mag_a;
	logic [W-1:0]    mag_b;
	logic [W:0]      rem_sh;
	logic [W:0]      add_x;
	logic [W:0]      add_y;
	logic [W:0]      add_sum;

	assign mag_a = a[W-1] ? (~a + W'(1)) : a;
	assign mag_b = b[W-1] ? (~b + W'(1)) : b;

	// The one adder: accumulates partial products, or trial-subtracts the divisor.
	assign rem_sh  = {acc_q, quo_q[W-1]};
	assign add_x   = div_q ? rem_sh : {1'b0, acc_q};
	assign add_y   = {1'b0, opnd_q};
	assign add_sum = div_q ? (add_x - add_y) : (add_x + add_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			iter_q  <= '0;
			div_q   <= 1'b0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
			quo_q   <= '0;
			opnd_q  <= '0;
			res_q   <= '0;
		end else begin
			done_q <= (state_q == MD_FIX);
			case (state_q)
				MD_IDLE: begin
					if (ctrl.start) begin
						div_q   <= ctrl.is_div;
						neg_q   <= a[W-1] ^ b[W-1];
						iter_q  <= '0;
						acc_q   <= '0;
						quo_q   <= ctrl.is_div ? mag_a : b;
						opnd_q  <= ctrl.is_div ? mag_b : a;
						state_q <= MD_RUN;
					end
				end
				MD_RUN: begin
					if (div_q) begin
						if (!add_sum[W]) begin
							acc_q <= add_sum[W-1:0];
							quo_q <= {quo_q[W-2:0], 1'b1};
						end else begin
							acc_q <= rem_sh[W-1:0];
							quo_q <= {quo_q[W-2:0], 1'b0};
						end
					end else begin
						if (quo_q[0]) begin
							acc_q <= add_sum[W-1:0];
						end
						opnd_q <= {opnd_q[W-2:0], 1'b0};
						quo_q  <= {1'b0, quo_q[W-1:1]};
					end
					iter_q <= iter_q + IW'(1);
					if (iter_q == IW'(W - 1)) begin
						state_q <= MD_FIX;
					end
				end
				MD_FIX: begin
					if (div_q) begin
						res_q <= neg_q ? (~quo_q + W'(1)) : quo_q;
					end else begin
						res_q <= acc_q;
					end
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != MD_IDLE);
	assign stat.done = done_q;
	assign res       = res_q;

endmodule

>>> rtl/postfix_stack_evaluator_unit.sv
// Postfix stack evaluator. Each item transfer either pushes a signed number,
// applies add, subtract, multiply or divide to the top two stack entries
// (a op b, with b the top entry), or ends the expression. Only an end item
// produces a result transfer: the final value and a status (ok, too few
// operands, divide by zero, leftover items, or overflow when a push finds the
// stack full). The first error of an expression is sticky; later push and
// operator items are ignored until the end item, which also clears the stack
// and the error. Arithmetic wraps to DATA_WIDTH bits and division truncates
// toward zero. Steps: a push, an unknown command, or an operator that meets
// a sticky error or too few entries is done in the accepting state; add and
// subtract read b and then a through the registered read port of the stack
// memory and write their result in the execute state, where a divide by
// zero is also caught; other multiplies and divides then run in the radix-2
// shared multiply/divide unit, which retires one bit per cycle, followed by
// its sign fixup and the write of its result; an end item moves to the end
// state and waits there for the result register to be taken. The block
// stalls the input while an item is in work.
module postfix_stack_evaluator_unit import pse_pkg::*; #(
	parameter int STACK_DEPTH = PSE_STACK_DEPTH,
	parameter int DATA_WIDTH  = PSE_DATA_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDA,
		ST_EXEC,
		ST_WAIT,
		ST_END
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [2:0]            err_q;
	logic [2:0]            op_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic                  result_valid_q;
	result_t               result_q;

	// Stack storage: one write port and one registered read port.
	logic [DATA_WIDTH-1:0] stack_q [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  accept;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         cnt_m2;
	logic [AW-1:0]         raddr;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] push_val;
	logic [DATA_WIDTH-1:0] addsub_val;
	logic [31:0]           final_val;
	logic                  out_free;
	logic                  push_ok;

	md_ctrl_t              md_ctrl;
	md_stat_t              md_stat;
	logic [DATA_WIDTH-1:0] md_res;

	assign accept   = item_valid && !item_stall;
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign out_free = !result_valid_q || !result_stall;

	// Width conversion between the 32-bit fields and the stack word.
	generate
		if (DATA_WIDTH == 32) begin : g_w32
			assign push_val  = item.operand;
			assign final_val = rdata_q;
		end else if (DATA_WIDTH > 32) begin : g_wide
			assign push_val  = {{(DATA_WIDTH - 32){item.operand[31]}}, item.operand};
			assign final_val = rdata_q[31:0];
		end else begin : g_narrow
			assign push_val  = item.operand[DATA_WIDTH-1:0];
			assign final_val = {{(32 - DATA_WIDTH){rdata_q[DATA_WIDTH-1]}}, rdata_q};
		end
	endgenerate

	assign addsub_val = (op_q == CMD_ADD) ? (rdata_q + b_q) : (rdata_q - b_q);

	assign push_ok = accept && (item.cmd == CMD_PUSH) && (err_q == STAT_OK)
		&& (cnt_q < CW'(STACK_DEPTH));

	// Read address: b on the accepting cycle, a in the cycle after it, entry zero for an end.
	always_comb begin
		raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (item.cmd != CMD_END) begin
					raddr = cnt_m1[AW-1:0];
				end
			end
			ST_RDA: begin
				raddr = cnt_m2[AW-1:0];
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_m2[AW-1:0];
		wdata = md_res;
		case (state_q)
			ST_IDLE: begin
				we    = push_ok;
				waddr = cnt_q[AW-1:0];
				wdata = push_val;
			end
			ST_EXEC: begin
				we    = (op_q == CMD_ADD) || (op_q == CMD_SUB);
				wdata = addsub_val;
			end
			ST_WAIT: begin
				we = md_stat.done;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stack_q[waddr] <= wdata;
		end
		rdata_q <= stack_q[raddr];
	end

	// Multiply and a divide by a nonzero b are started once both operands are in hand.
	assign md_ctrl.start  = (state_q == ST_EXEC)
		&& ((op_q == CMD_MUL) || ((op_q == CMD_DIV) && (b_q != '0)));
	assign md_ctrl.is_div = (op_q == CMD_DIV);

	pse_muldiv #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (md_ctrl),
		.a     (rdata_q),
		.b     (b_q),
		.stat  (md_stat),
		.res   (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			err_q          <= STAT_OK;
			op_q           <= CMD_PUSH;
			b_q            <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != ST_END)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_PUSH: begin
								if (err_q == STAT_OK) begin
									if (push_ok) begin
										cnt_q <= cnt_q + CW'(1);
									end else begin
										err_q <= STAT_OVF;
									end
								end
							end
							CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
								if (err_q == STAT_OK) begin
									if (cnt_q < CW'(2)) begin
										err_q <= STAT_FEW;
									end else begin
										op_q    <= item.cmd;
										state_q <= ST_RDA;
									end
								end
							end
							CMD_END: begin
								state_q <= ST_END;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RDA: begin
					b_q     <= rdata_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if ((op_q == CMD_ADD) || (op_q == CMD_SUB)) begin
						cnt_q   <= cnt_m1;
						state_q <= ST_IDLE;
					end else if ((op_q == CMD_DIV) && (b_q == '0)) begin
						err_q   <= STAT_DIVZ;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (md_stat.done) begin
						cnt_q   <= cnt_m1;
						state_q <= ST_IDLE;
					end
				end
				ST_END: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						if (err_q != STAT_OK) begin
							result_q.status <= err_q;
							result_q.value  <= '0;
						end else if (cnt_q == '0) begin
							result_q.status <= STAT_FEW;
							result_q.value  <= '0;
						end else if (cnt_q != CW'(1)) begin
							result_q.status <= STAT_LEFT;
							result_q.value  <= '0;
						end else begin
							result_q.status <= STAT_OK;
							result_q.value  <= final_val;
						end
						cnt_q   <= '0;
						err_q   <= STAT_OK;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The stack count never passes the depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// A failed expression always reports a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != STAT_OK)) |-> (result.value == '0))
		else $error("nonzero value with error status");

	// The multiply/divide unit is started only when free, and finishes only while awaited.
	a_md_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_ctrl.start |-> !md_stat.busy)
		else $error("multiply/divide started while busy");

	a_md_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |-> (state_q == ST_WAIT))
		else $error("multiply/divide result with no waiting operator");

endmodule
